[rtl/core/rgbh_pkg.sv]
// ----------------------------------------------------------------------------
// rgbh_pkg
// Shared types and constants for the RGB grey average and histogram unit.
// ----------------------------------------------------------------------------
package rgbh_pkg;

   // Field widths of the request and response transfers.
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned OP_W        = 2;
   localparam int unsigned IDX_W       = 4;
   localparam int unsigned GRAY_W      = 8;
   localparam int unsigned OUT_COUNT_W = 24;

   // Widest internal count that the counters may have.
   localparam int unsigned COUNT_MAX_W = 32;

   // Bin index extended far enough to compare with any bin count up to 256.
   localparam int unsigned IDX_EXT_W = 9;

   // Channel sum and the divide-by-three reciprocal: floor(s / 3) equals
   // (s * 683) >> 11 for every sum of three 8-bit channels.
   localparam int unsigned SUM_W        = 10;
   localparam int unsigned GRAY_PROD_W  = 20;
   localparam logic [SUM_W-1:0] DIV3_RECIP = 10'd683;
   localparam int unsigned DIV3_SHIFT   = 11;

   // Width of the channel value times the bin count.
   localparam int unsigned BIN_PROD_W = 17;

   // Operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_PIXEL = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Per-lane update controls for one accepted transfer.
   typedef struct packed {
      logic bump;
      logic clear;
   } lane_ctrl_type;

   // One response transfer.
   typedef struct packed {
      logic [GRAY_W-1:0]      gray;
      logic [OUT_COUNT_W-1:0] blue_count;
      logic [OUT_COUNT_W-1:0] green_count;
      logic [OUT_COUNT_W-1:0] red_count;
   } rsp_payload_type;

endpackage

[rtl/core/rgbh_req_if.sv]
// ----------------------------------------------------------------------------
// rgbh_req_if
// Request channel: valid/ready handshake with operation, pixel and bin index.
// ----------------------------------------------------------------------------
interface rgbh_req_if;

   logic                              valid;
   logic                              ready;
   logic [rgbh_pkg::OP_W-1:0]         operation;
   logic [rgbh_pkg::CHAN_W-1:0]       blue;
   logic [rgbh_pkg::CHAN_W-1:0]       green;
   logic [rgbh_pkg::CHAN_W-1:0]       red;
   logic [rgbh_pkg::IDX_W-1:0]        bin_index;

   modport source (
      output valid, operation, blue, green, red, bin_index,
      input  ready
   );

   modport sink (
      input  valid, operation, blue, green, red, bin_index,
      output ready
   );

endinterface

[rtl/core/rgbh_rsp_if.sv]
// ----------------------------------------------------------------------------
// rgbh_rsp_if
// Response channel: valid/ready handshake with grey value and bin counts.
// ----------------------------------------------------------------------------
interface rgbh_rsp_if;

   logic                               valid;
   logic                               ready;
   logic [rgbh_pkg::GRAY_W-1:0]        gray;
   logic [rgbh_pkg::OUT_COUNT_W-1:0]   blue_count;
   logic [rgbh_pkg::OUT_COUNT_W-1:0]   green_count;
   logic [rgbh_pkg::OUT_COUNT_W-1:0]   red_count;

   modport source (
      output valid, gray, blue_count, green_count, red_count,
      input  ready
   );

   modport sink (
      input  valid, gray, blue_count, green_count, red_count,
      output ready
   );

endinterface

[rtl/core/rgb_gray_average_with_histograms_unit.sv]
// ----------------------------------------------------------------------------
// rgb_gray_average_with_histograms_unit
// Grey average of BGR pixels with a saturating histogram per colour channel.
// ----------------------------------------------------------------------------
// Use: every request transfer carries an operation. A pixel operation
// returns the floor of the mean of blue, green and red and counts each
// channel into its own histogram, binned by (value * BIN_COUNT) >> 8.
// A read operation returns the three counts of bin_index (zero when the
// index is beyond the last bin). A clear operation zeroes every bin.
// Every request gives exactly one response; unused fields read as zero,
// and an unused operation code changes nothing and returns all zero.
// Responses are registered in the output buffer. One request is taken
// every cycle while req_port.ready is high; the three channel lanes
// update their counter rows in that same cycle, so a request directly
// after a pixel sees its counts. Reset empties the response buffer and
// clears all counters at once; requests are taken from the first cycle
// after it. When the receiver stalls, one further request is held in a
// skid register, after which req_port.ready drops until the output drains.
// ----------------------------------------------------------------------------
module rgb_gray_average_with_histograms_unit #(
   parameter int unsigned BIN_COUNT   = 16,
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  logic           clock,
   input  logic           reset,
   rgbh_req_if.sink       req_port,
   rgbh_rsp_if.source     rsp_port
);

   localparam int unsigned BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

   logic                              accept;
   rgbh_pkg::op_type                  op;
   rgbh_pkg::lane_ctrl_type           lane_ctrl;
   logic [rgbh_pkg::IDX_EXT_W-1:0]    idx_ext;
   logic                              idx_in_range;
   logic [BIN_W-1:0]                  read_index;
   logic [COUNT_WIDTH-1:0]            blue_cnt;
   logic [COUNT_WIDTH-1:0]            green_cnt;
   logic [COUNT_WIDTH-1:0]            red_cnt;
   logic [rgbh_pkg::COUNT_MAX_W-1:0]  blue_ext;
   logic [rgbh_pkg::COUNT_MAX_W-1:0]  green_ext;
   logic [rgbh_pkg::COUNT_MAX_W-1:0]  red_ext;
   logic [rgbh_pkg::GRAY_W-1:0]       gray_val;
   rgbh_pkg::rsp_payload_type         rsp_data;
   rgbh_pkg::rsp_payload_type         buf_data;
   logic                              buf_ready;

   assign accept = req_port.valid && buf_ready;
   assign req_port.ready = buf_ready;
   assign op = rgbh_pkg::op_type'(req_port.operation);

   // Lane controls for the accepted transfer.
   assign lane_ctrl.bump  = accept && (op == rgbh_pkg::OP_PIXEL);
   assign lane_ctrl.clear = accept && (op == rgbh_pkg::OP_CLEAR);

   // Bin selection for reads, with a range check against the bin count.
   assign idx_ext      = rgbh_pkg::IDX_EXT_W'(req_port.bin_index);
   assign idx_in_range = idx_ext < rgbh_pkg::IDX_EXT_W'(BIN_COUNT);
   assign read_index   = idx_ext[BIN_W-1:0];

   rgbh_gray u_gray (
      .blue  (req_port.blue),
      .green (req_port.green),
      .red   (req_port.red),
      .gray  (gray_val)
   );

   // One lane per colour channel.
   rgbh_lane #(.BIN_COUNT(BIN_COUNT), .COUNT_WIDTH(COUNT_WIDTH)) u_lane_blue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (lane_ctrl),
      .value      (req_port.blue),
      .read_index (read_index),
      .read_count (blue_cnt)
   );

   rgbh_lane #(.BIN_COUNT(BIN_COUNT), .COUNT_WIDTH(COUNT_WIDTH)) u_lane_green (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (lane_ctrl),
      .value      (req_port.green),
      .read_index (read_index),
      .read_count (green_cnt)
   );

   rgbh_lane #(.BIN_COUNT(BIN_COUNT), .COUNT_WIDTH(COUNT_WIDTH)) u_lane_red (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (lane_ctrl),
      .value      (req_port.red),
      .read_index (read_index),
      .read_count (red_cnt)
   );

   // Counts go out at the fixed response width.
   assign blue_ext  = rgbh_pkg::COUNT_MAX_W'(blue_cnt);
   assign green_ext = rgbh_pkg::COUNT_MAX_W'(green_cnt);
   assign red_ext   = rgbh_pkg::COUNT_MAX_W'(red_cnt);

   // Merge the lane results into one response.
   always_comb begin
      rsp_data = '0;
      unique case (op)
         rgbh_pkg::OP_PIXEL: begin
            rsp_data.gray = gray_val;
         end
         rgbh_pkg::OP_READ: begin
            if (idx_in_range) begin
               rsp_data.blue_count  = blue_ext[rgbh_pkg::OUT_COUNT_W-1:0];
               rsp_data.green_count = green_ext[rgbh_pkg::OUT_COUNT_W-1:0];
               rsp_data.red_count   = red_ext[rgbh_pkg::OUT_COUNT_W-1:0];
            end
         end
         rgbh_pkg::OP_CLEAR: begin
            rsp_data = '0;
         end
         default: begin
            rsp_data = '0;
         end
      endcase
   end

   rgbh_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (buf_ready),
      .in_data   (rsp_data),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_data  (buf_data)
   );

   assign rsp_port.gray        = buf_data.gray;
   assign rsp_port.blue_count  = buf_data.blue_count;
   assign rsp_port.green_count = buf_data.green_count;
   assign rsp_port.red_count   = buf_data.red_count;

   // A transfer taken while the output was empty shows up the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !rsp_port.valid) |=> rsp_port.valid)
      else $error("response missing one cycle after an accepted request");

   // After a clear every lane reads zero, whatever bin is selected.
   assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.clear |=> ((blue_cnt == '0) && (green_cnt == '0) && (red_cnt == '0)))
      else $error("histogram not empty after a clear");

   // Back-pressure only arises with a response waiting at the output.
   assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> rsp_port.valid)
      else $error("request stalled while no response is pending");

endmodule

[rtl/core/rgbh_gray.sv]
// ----------------------------------------------------------------------------
// rgbh_gray
// Grey value of one pixel: the floor of the channel mean.
// ----------------------------------------------------------------------------
module rgbh_gray (
   input  logic [rgbh_pkg::CHAN_W-1:0] blue,
   input  logic [rgbh_pkg::CHAN_W-1:0] green,
   input  logic [rgbh_pkg::CHAN_W-1:0] red,
   output logic [rgbh_pkg::GRAY_W-1:0] gray
);

   logic [rgbh_pkg::SUM_W-1:0]       sum;
   logic [rgbh_pkg::GRAY_PROD_W-1:0] prod;

   // Sum of the three channels, then division by three as a multiplication
   // by a scaled reciprocal.
   assign sum  = rgbh_pkg::SUM_W'(blue) + rgbh_pkg::SUM_W'(green)
               + rgbh_pkg::SUM_W'(red);
   assign prod = rgbh_pkg::GRAY_PROD_W'(sum)
               * rgbh_pkg::GRAY_PROD_W'(rgbh_pkg::DIV3_RECIP);
   assign gray = prod[rgbh_pkg::DIV3_SHIFT +: rgbh_pkg::GRAY_W];

endmodule

[rtl/core/rgbh_lane.sv]
// ----------------------------------------------------------------------------
// rgbh_lane
// Histogram lane for one colour channel: a row of saturating bin counters
// and a read selector.
// ----------------------------------------------------------------------------
module rgbh_lane #(
   parameter int unsigned BIN_COUNT   = 16,
   parameter int unsigned COUNT_WIDTH = 24,
   localparam int unsigned BIN_W      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rgbh_pkg::lane_ctrl_type       ctrl,
   input  logic [rgbh_pkg::CHAN_W-1:0]   value,
   input  logic [BIN_W-1:0]              read_index,
   output logic [COUNT_WIDTH-1:0]        read_count
);

   logic [COUNT_WIDTH-1:0]          bins_ff [BIN_COUNT];
   logic [COUNT_WIDTH-1:0]          bins_in [BIN_COUNT];
   logic [rgbh_pkg::BIN_PROD_W-1:0] bin_prod;
   logic [BIN_W-1:0]                bump_bin;

   // The bin is (value * BIN_COUNT) >> 8, always below BIN_COUNT.
   assign bin_prod = rgbh_pkg::BIN_PROD_W'(value) * rgbh_pkg::BIN_PROD_W'(BIN_COUNT);
   assign bump_bin = bin_prod[rgbh_pkg::CHAN_W +: BIN_W];

   // Each counter cell clears, or counts up when its bin is hit and it is
   // not yet full.
   always_comb begin
      for (int unsigned i = 0; i < BIN_COUNT; i++) begin
         if (ctrl.clear) begin
            bins_in[i] = '0;
         end else if (ctrl.bump && (bump_bin == BIN_W'(i)) && (bins_ff[i] != '1)) begin
            bins_in[i] = bins_ff[i] + COUNT_WIDTH'(1);
         end else begin
            bins_in[i] = bins_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int unsigned i = 0; i < BIN_COUNT; i++) begin
         if (reset) begin
            bins_ff[i] <= '0;
         end else begin
            bins_ff[i] <= bins_in[i];
         end
      end
   end

   // Count held before the current transfer takes effect.
   assign read_count = bins_ff[read_index];

endmodule

[rtl/core/rgbh_out_buf.sv]
// ----------------------------------------------------------------------------
// rgbh_out_buf
// Two-entry response buffer: an output register with a skid register, so
// that a transfer can still be taken in the cycle the receiver stalls.
// ----------------------------------------------------------------------------
module rgbh_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rgbh_pkg::rsp_payload_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rgbh_pkg::rsp_payload_type out_data
);

   logic                      main_valid_ff;
   logic                      main_valid_in;
   rgbh_pkg::rsp_payload_type main_data_ff;
   rgbh_pkg::rsp_payload_type main_data_in;
   logic                      skid_valid_ff;
   logic                      skid_valid_in;
   rgbh_pkg::rsp_payload_type skid_data_ff;
   rgbh_pkg::rsp_payload_type skid_data_in;
   logic                      take_in;

   assign in_ready = !skid_valid_ff;
   assign take_in  = in_valid && in_ready;

   // The output register refills from the skid register first, then from
   // the input; a new transfer parks in the skid register while stalled.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || out_ready) begin
         main_valid_in = skid_valid_ff || take_in;
         main_data_in  = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (take_in) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule
